// ===== rtl/tea_pkg.sv =====
// Types, constants and the round mixing function of the TEA block cipher.
// Depends on nothing. Used by tea_round and tea_block_cipher.
`default_nettype none

package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE  = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t half_left_in;
    word_t half_right_in;
  } in_block_t;

  typedef struct packed {
    word_t half_left_out;
    word_t half_right_out;
  } out_block_t;

  // Working pair inside the pipeline: y is the left word, z the right word.
  typedef struct packed {
    word_t y;
    word_t z;
  } pair_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  function automatic word_t tea_mix(input word_t v, input word_t sum,
                                    input word_t kl, input word_t kr);
    word_t a;
    word_t b;
    word_t c;
    a = (v << 4) + kl;
    b = v + sum;
    c = (v >> 5) + kr;
    return a ^ b ^ c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tea_round.sv =====
// One TEA round as two register stages, one half-round each.
// Depends on tea_pkg for the pair and key types and the mixing function.
`default_nettype none

module tea_round (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire tea_pkg::pair_t pair_in,
  input  wire tea_pkg::word_t sum,
  input  wire tea_pkg::key_t  key,
  input  wire logic          decrypt,
  output logic               valid_out,
  output tea_pkg::pair_t      pair_out
);
  import tea_pkg::*;

  logic  valid_mid;
  pair_t pair_mid;
  pair_t pair_mid_next;
  pair_t pair_out_next;
  word_t mix_a;
  word_t mix_b;

  // Encryption updates y then z; decryption undoes z then y.
  always_comb begin
    pair_mid_next = pair_in;
    if (decrypt) begin
      mix_a = tea_mix(pair_in.y, sum, key.k2, key.k3);
      pair_mid_next.z = pair_in.z - mix_a;
    end else begin
      mix_a = tea_mix(pair_in.z, sum, key.k0, key.k1);
      pair_mid_next.y = pair_in.y + mix_a;
    end
  end

  always_comb begin
    pair_out_next = pair_mid;
    if (decrypt) begin
      mix_b = tea_mix(pair_mid.z, sum, key.k0, key.k1);
      pair_out_next.y = pair_mid.y - mix_b;
    end else begin
      mix_b = tea_mix(pair_mid.y, sum, key.k2, key.k3);
      pair_out_next.z = pair_mid.z + mix_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mid <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid_mid <= valid_in;
      valid_out <= valid_mid;
    end
  end

  always_ff @(posedge clk) begin
    pair_mid <= pair_mid_next;
    pair_out <= pair_out_next;
  end

endmodule

`default_nettype wire

// ===== rtl/tea_block_cipher.sv =====
// Top level of the pipelined TEA block cipher: configuration registers
// and a chain of tea_round instances. Depends on tea_pkg and tea_round.
//
// Usage:
//   A block is accepted at a rising edge with start high and busy low.
//   busy is never raised, so a new block can enter in every cycle.
//   Each round takes two pipeline stages, so the result appears on
//   result with done high once its block has passed the stages of every
//   round, one result per cycle, in the order the blocks came in.
//   done lasts one cycle; the receiver takes every result as it comes.
//   Keys and the mode are written through cfg_valid/cfg_ready with
//   cfg_index selecting key word 0..3 or the mode (4); other indexes are
//   ignored. cfg_ready is always high. Write them only while no block
//   is in flight, since every stage reads the live registers.
//   Reset clears the keys, selects encryption and empties the pipeline.
`default_nettype none

module tea_block_cipher #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire tea_pkg::in_block_t             source,
  output logic                                done,
  output tea_pkg::out_block_t                 result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire tea_pkg::word_t                 cfg_data
);
  import tea_pkg::*;

  key_t key;
  logic decrypt;

  logic  chain_valid [ROUND_COUNT+1];
  pair_t chain_pair  [ROUND_COUNT+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key     <= '0;
      decrypt <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_0: key.k0  <= cfg_data;
        REG_KEY_1: key.k1  <= cfg_data;
        REG_KEY_2: key.k2  <= cfg_data;
        REG_KEY_3: key.k3  <= cfg_data;
        REG_MODE:  decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign chain_valid[0]  = start && !busy;
  assign chain_pair[0].y = source.half_left_in;
  assign chain_pair[0].z = source.half_right_in;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    // Round sums are fixed per position: encryption counts up from delta,
    // decryption counts down from delta times the round count.
    localparam word_t SUM_ENC = WORD_W'(64'(TEA_DELTA) * 64'(r + 1));
    localparam word_t SUM_DEC = WORD_W'(64'(TEA_DELTA) * 64'(ROUND_COUNT - r));

    word_t round_sum;
    assign round_sum = decrypt ? SUM_DEC : SUM_ENC;

    tea_round u_round (
      .clk      (clk),
      .rst      (rst),
      .valid_in (chain_valid[r]),
      .pair_in  (chain_pair[r]),
      .sum      (round_sum),
      .key      (key),
      .decrypt  (decrypt),
      .valid_out(chain_valid[r+1]),
      .pair_out (chain_pair[r+1])
    );
  end

  assign done                  = chain_valid[ROUND_COUNT];
  assign result.half_left_out  = chain_pair[ROUND_COUNT].y;
  assign result.half_right_out = chain_pair[ROUND_COUNT].z;

endmodule

`default_nettype wire
